[hw/rtl/etl_pkg.sv]
package etl_pkg;

    // lexing modes
    localparam logic [2:0] M_IDLE      = 3'd0;
    localparam logic [2:0] M_ZERO      = 3'd1;
    localparam logic [2:0] M_DEC       = 3'd2;
    localparam logic [2:0] M_BIN_EMPTY = 3'd3;
    localparam logic [2:0] M_BIN       = 3'd4;
    localparam logic [2:0] M_HEX_EMPTY = 3'd5;
    localparam logic [2:0] M_HEX       = 3'd6;
    localparam logic [2:0] M_OCT       = 3'd7;

    typedef logic [3:0] token_kind_t;
    typedef logic [2:0] error_code_t;

    localparam token_kind_t K_PLUS   = 4'd0;
    localparam token_kind_t K_MINUS  = 4'd1;
    localparam token_kind_t K_STAR   = 4'd2;
    localparam token_kind_t K_SLASH  = 4'd3;
    localparam token_kind_t K_LPAREN = 4'd4;
    localparam token_kind_t K_RPAREN = 4'd5;
    localparam token_kind_t K_DEC    = 4'd6;
    localparam token_kind_t K_BIN    = 4'd7;
    localparam token_kind_t K_HEX    = 4'd8;
    localparam token_kind_t K_OCT    = 4'd9;
    localparam token_kind_t K_EOF    = 4'd10;
    localparam token_kind_t K_ERR    = 4'd11;

    localparam error_code_t E_NONE       = 3'd0;
    localparam error_code_t E_UNEXPECTED = 3'd1;
    localparam error_code_t E_NO_BITS    = 3'd2;
    localparam error_code_t E_BAD_BIN    = 3'd3;
    localparam error_code_t E_NO_HEX     = 3'd4;
    localparam error_code_t E_BAD_OCT    = 3'd5;

    localparam logic [7:0] CH_TAB    = 8'd9;
    localparam logic [7:0] CH_NL     = 8'd10;
    localparam logic [7:0] CH_CR     = 8'd13;
    localparam logic [7:0] CH_SPACE  = 8'd32;
    localparam logic [7:0] CH_PLUS   = 8'h2b;
    localparam logic [7:0] CH_MINUS  = 8'h2d;
    localparam logic [7:0] CH_STAR   = 8'h2a;
    localparam logic [7:0] CH_SLASH  = 8'h2f;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_1      = 8'h31;
    localparam logic [7:0] CH_7      = 8'h37;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_B   = 8'h62;
    localparam logic [7:0] CH_LO_F   = 8'h66;
    localparam logic [7:0] CH_LO_X   = 8'h78;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_F   = 8'h46;

    typedef struct packed {
        token_kind_t token_kind;
        error_code_t error_code;
        logic [15:0] start_index;
        logic [15:0] end_index;
        logic [15:0] start_line;
        logic [15:0] start_column;
        logic        last_of_run;
    } lex_result_t;

    function automatic logic is_digit(input logic [7:0] ch);
        return (ch >= CH_0) && (ch <= CH_9);
    endfunction

    function automatic logic is_hex(input logic [7:0] ch);
        return is_digit(ch) || ((ch >= CH_LO_A) && (ch <= CH_LO_F))
            || ((ch >= CH_UP_A) && (ch <= CH_UP_F));
    endfunction

    function automatic logic is_space(input logic [7:0] ch);
        return (ch == CH_SPACE) || ((ch >= CH_TAB) && (ch <= CH_CR));
    endfunction

endpackage

[hw/rtl/etl_in_if.sv]
interface etl_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_byte;
    logic       end_of_source;

    modport source (output valid, output char_byte, output end_of_source, input ready);
    modport sink (input valid, input char_byte, input end_of_source, output ready);
endinterface

[hw/rtl/etl_out_if.sv]
interface etl_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  token_kind;
    logic [2:0]  error_code;
    logic [15:0] start_index;
    logic [15:0] end_index;
    logic [15:0] start_line;
    logic [15:0] start_column;
    logic        last_of_run;

    modport source (
        output valid, output token_kind, output error_code, output start_index,
        output end_index, output start_line, output start_column, output last_of_run,
        input ready
    );
    modport sink (
        input valid, input token_kind, input error_code, input start_index,
        input end_index, input start_line, input start_column, input last_of_run,
        output ready
    );
endinterface

[hw/rtl/expression_token_lexer.sv]
// channel  | modport           | request
// ---------+-------------------+------------------------------------------
// chars    | etl_in_if.sink    | one source byte or the end-of-source mark
// tokens   | etl_out_if.source | one token or error, last_of_run on the last
//
// a byte enters an input register, is lexed once the result register is free and its
// results land in a two-entry result register; one byte per cycle while the tokens
// channel is ready and each byte gives at most one result; a byte that closes a number
// and emits a second token holds the lexer until both of its results leave the single
// output port of the result register; reset returns to idle mode at index 0, line 1, column 1
// a stalled tokens channel holds the lexer and then the chars channel
module expression_token_lexer #(
    parameter int POSITION_BITS = 16
) (
    input logic        clk,
    input logic        rst_n,
    etl_in_if.sink     chars,
    etl_out_if.source  tokens
);
    import etl_pkg::*;

    localparam int P = POSITION_BITS;
    localparam logic [P-1:0] POS_ONE = {{(P-1){1'b0}}, 1'b1};

    logic         in_valid_reg;
    logic [7:0]   char_reg;
    logic         eos_reg;

    logic [2:0]   mode_reg, mode_next;
    logic         bad_reg, bad_next;
    logic [P-1:0] tsi_reg, tsi_next;
    logic [P-1:0] tsl_reg, tsl_next;
    logic [P-1:0] tsc_reg, tsc_next;
    logic [P-1:0] ci_reg, ci_next;
    logic [P-1:0] cl_reg, cl_next;
    logic [P-1:0] cc_reg, cc_next;

    logic         buf_free;
    logic         fire;
    logic         consumed;
    logic [2:0]   mode_c;
    logic         bad_c;
    logic         flush_valid;
    logic         second_valid;
    logic         is_op;
    token_kind_t  op_kind;
    token_kind_t  flush_kind;
    error_code_t  flush_err;
    logic [P-1:0] ci_adv, cl_adv, cc_adv;
    lex_result_t  flush_res;
    lex_result_t  second_res;
    lex_result_t  first_out;
    lex_result_t  second_out;

    function automatic logic [P-1:0] sat_inc(input logic [P-1:0] v);
        return (v == {P{1'b1}}) ? v : v + POS_ONE;
    endfunction

    function automatic logic [15:0] pos16(input logic [P-1:0] v);
        logic [P+15:0] w;
        w = {16'd0, v};
        return w[15:0];
    endfunction

    assign fire         = in_valid_reg && buf_free;
    assign chars.ready  = !in_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (chars.valid && chars.ready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (chars.valid && chars.ready)
        begin
            char_reg <= chars.char_byte;
            eos_reg  <= chars.end_of_source;
        end
    end

    // mode step for a byte that may extend the pending number
    always_comb
    begin
        consumed = 1'b0;
        mode_c   = mode_reg;
        bad_c    = bad_reg;
        unique case (mode_reg) inside
            M_ZERO:
            begin
                if (char_reg == CH_LO_B)
                begin
                    mode_c   = M_BIN_EMPTY;
                    consumed = 1'b1;
                end
                else if (char_reg == CH_LO_X)
                begin
                    mode_c   = M_HEX_EMPTY;
                    consumed = 1'b1;
                end
                else if (is_digit(char_reg))
                begin
                    mode_c   = M_OCT;
                    bad_c    = bad_reg || (char_reg > CH_7);
                    consumed = 1'b1;
                end
            end
            M_DEC:
            begin
                consumed = is_digit(char_reg);
            end
            M_BIN_EMPTY, M_BIN:
            begin
                if (is_digit(char_reg))
                begin
                    mode_c   = M_BIN;
                    bad_c    = bad_reg || (char_reg > CH_1);
                    consumed = 1'b1;
                end
            end
            M_HEX_EMPTY, M_HEX:
            begin
                if (is_hex(char_reg))
                begin
                    mode_c   = M_HEX;
                    consumed = 1'b1;
                end
            end
            M_OCT:
            begin
                if (is_digit(char_reg))
                begin
                    bad_c    = bad_reg || (char_reg > CH_7);
                    consumed = 1'b1;
                end
            end
            default:
            begin
                consumed = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        flush_kind = K_OCT;
        flush_err  = E_NONE;
        unique case (mode_reg)
            M_ZERO:      flush_kind = K_OCT;
            M_DEC:       flush_kind = K_DEC;
            M_BIN_EMPTY:
            begin
                flush_kind = K_ERR;
                flush_err  = E_NO_BITS;
            end
            M_BIN:
            begin
                flush_kind = bad_reg ? K_ERR : K_BIN;
                flush_err  = bad_reg ? E_BAD_BIN : E_NONE;
            end
            M_HEX_EMPTY:
            begin
                flush_kind = K_ERR;
                flush_err  = E_NO_HEX;
            end
            M_HEX:       flush_kind = K_HEX;
            M_OCT:
            begin
                flush_kind = bad_reg ? K_ERR : K_OCT;
                flush_err  = bad_reg ? E_BAD_OCT : E_NONE;
            end
            default:     flush_kind = K_OCT;
        endcase
    end

    always_comb
    begin
        is_op   = 1'b1;
        op_kind = K_PLUS;
        case (char_reg)
            CH_PLUS:   op_kind = K_PLUS;
            CH_MINUS:  op_kind = K_MINUS;
            CH_STAR:   op_kind = K_STAR;
            CH_SLASH:  op_kind = K_SLASH;
            CH_LPAREN: op_kind = K_LPAREN;
            CH_RPAREN: op_kind = K_RPAREN;
            default:   is_op = 1'b0;
        endcase
    end

    assign ci_adv = sat_inc(ci_reg);
    assign cl_adv = (char_reg == CH_NL) ? sat_inc(cl_reg) : cl_reg;
    assign cc_adv = (char_reg == CH_NL) ? POS_ONE : sat_inc(cc_reg);

    always_comb
    begin
        flush_res.token_kind   = flush_kind;
        flush_res.error_code   = flush_err;
        flush_res.start_index  = pos16(tsi_reg);
        flush_res.end_index    = pos16(ci_reg);
        flush_res.start_line   = pos16(tsl_reg);
        flush_res.start_column = pos16(tsc_reg);
        flush_res.last_of_run  = 1'b0;

        second_res.start_index  = pos16(ci_reg);
        second_res.start_line   = pos16(cl_reg);
        second_res.start_column = pos16(cc_reg);
        second_res.last_of_run  = 1'b1;
        if (eos_reg)
        begin
            second_res.token_kind = K_EOF;
            second_res.error_code = E_NONE;
            second_res.end_index  = pos16(ci_reg);
        end
        else
        begin
            second_res.token_kind = is_op ? op_kind : K_ERR;
            second_res.error_code = is_op ? E_NONE : E_UNEXPECTED;
            second_res.end_index  = pos16(ci_adv);
        end
    end

    always_comb
    begin
        flush_valid  = (mode_reg != M_IDLE) && (eos_reg || !consumed);
        second_valid = eos_reg || (!consumed && !is_space(char_reg)
                       && (is_op || !is_digit(char_reg)));

        first_out             = flush_valid ? flush_res : second_res;
        first_out.last_of_run = !(flush_valid && second_valid);
        second_out            = second_res;
    end

    always_comb
    begin
        mode_next = mode_reg;
        bad_next  = bad_reg;
        tsi_next  = tsi_reg;
        tsl_next  = tsl_reg;
        tsc_next  = tsc_reg;
        ci_next   = ci_reg;
        cl_next   = cl_reg;
        cc_next   = cc_reg;
        if (eos_reg)
        begin
            mode_next = M_IDLE;
            bad_next  = 1'b0;
            tsi_next  = '0;
            tsl_next  = POS_ONE;
            tsc_next  = POS_ONE;
            ci_next   = '0;
            cl_next   = POS_ONE;
            cc_next   = POS_ONE;
        end
        else
        begin
            ci_next = ci_adv;
            cl_next = cl_adv;
            cc_next = cc_adv;
            if (consumed)
            begin
                mode_next = mode_c;
                bad_next  = bad_c;
            end
            else
            begin
                mode_next = M_IDLE;
                bad_next  = 1'b0;
                if (!is_space(char_reg))
                begin
                    tsi_next = ci_reg;
                    tsl_next = cl_reg;
                    tsc_next = cc_reg;
                    if (!is_op && (char_reg >= CH_1) && (char_reg <= CH_9))
                    begin
                        mode_next = M_DEC;
                    end
                    else if (!is_op && (char_reg == CH_0))
                    begin
                        mode_next = M_ZERO;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_IDLE;
            bad_reg  <= 1'b0;
            tsi_reg  <= '0;
            tsl_reg  <= POS_ONE;
            tsc_reg  <= POS_ONE;
            ci_reg   <= '0;
            cl_reg   <= POS_ONE;
            cc_reg   <= POS_ONE;
        end
        else if (fire)
        begin
            mode_reg <= mode_next;
            bad_reg  <= bad_next;
            tsi_reg  <= tsi_next;
            tsl_reg  <= tsl_next;
            tsc_reg  <= tsc_next;
            ci_reg   <= ci_next;
            cl_reg   <= cl_next;
            cc_reg   <= cc_next;
        end
    end

    etl_res_buf u_res_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (fire && (flush_valid || second_valid)),
        .load_two   (flush_valid && second_valid),
        .first_res  (first_out),
        .second_res (second_out),
        .free       (buf_free),
        .tokens     (tokens)
    );

endmodule

[hw/rtl/etl_res_buf.sv]
module etl_res_buf (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  logic                 load_two,
    input  etl_pkg::lex_result_t first_res,
    input  etl_pkg::lex_result_t second_res,
    output logic                 free,
    etl_out_if.source            tokens
);
    import etl_pkg::*;

    logic        valid_reg;
    logic        two_reg;
    logic        sel_reg;
    lex_result_t r0_reg;
    lex_result_t r1_reg;
    lex_result_t cur;
    logic        last_out;
    logic        take;

    assign cur      = sel_reg ? r1_reg : r0_reg;
    assign last_out = !two_reg || sel_reg;
    assign take     = valid_reg && tokens.ready;
    assign free     = !valid_reg || (take && last_out);

    assign tokens.valid        = valid_reg;
    assign tokens.token_kind   = cur.token_kind;
    assign tokens.error_code   = cur.error_code;
    assign tokens.start_index  = cur.start_index;
    assign tokens.end_index    = cur.end_index;
    assign tokens.start_line   = cur.start_line;
    assign tokens.start_column = cur.start_column;
    assign tokens.last_of_run  = cur.last_of_run;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            two_reg   <= 1'b0;
            sel_reg   <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
            two_reg   <= load_two;
            sel_reg   <= 1'b0;
        end
        else if (take)
        begin
            if (last_out)
            begin
                valid_reg <= 1'b0;
            end
            else
            begin
                sel_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            r0_reg <= first_res;
            r1_reg <= second_res;
        end
    end

endmodule
